>>> hw/rtl/bslp_pkg.sv
// shared types, constants and field layout for the button press classifier
package bslp_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int NUM_CHANNELS = 4;
    localparam int CH_WIDTH = 2;
    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // stream layouts
    localparam int S_FIELD_BITS = 3 + TIME_WIDTH;
    localparam int S_TDATA_WIDTH = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int KIND_WIDTH = 2;
    localparam int M_TDATA_WIDTH = 8;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(2000);
    localparam logic [CFG_WIDTH-1:0] LOCKOUT_RESET = CFG_WIDTH'(500);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOCKOUT = 2'd1;

    localparam logic [CH_WIDTH-1:0] CH_LEFT = 2'd0;
    localparam logic [CH_WIDTH-1:0] CH_MIDDLE = 2'd1;
    localparam logic [CH_WIDTH-1:0] CH_RIGHT = 2'd2;
    localparam logic [CH_WIDTH-1:0] CH_COMBO = 2'd3;

    localparam logic [KIND_WIDTH-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SHORT = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_LONG = 2'd2;

    typedef struct packed {
        logic                  armed;
        logic [TIME_WIDTH-1:0] press_start;
        logic                  held_block;
        logic                  lockout_active;
        logic [TIME_WIDTH-1:0] release_time;
    } chan_state_t;

    typedef struct packed {
        logic [CH_WIDTH-1:0]   channel;
        logic                  left_level;
        logic                  mid_level;
        logic                  right_level;
        logic [TIME_WIDTH-1:0] time_ms;
    } poll_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] long_press_ms;
        logic [CFG_WIDTH-1:0] lockout_ms;
    } cfg_t;

endpackage

>>> hw/rtl/bslp_chan_update.sv
// next-state and result logic for the one channel a poll selects
module bslp_chan_update (
    input  bslp_pkg::poll_t                   poll,
    input  bslp_pkg::cfg_t                    cfg,
    input  bslp_pkg::chan_state_t             cur,
    output bslp_pkg::chan_state_t             nxt,
    output logic [bslp_pkg::KIND_WIDTH-1:0]   kind
);
    import bslp_pkg::*;

    logic                  press_ok;
    logic                  released;
    logic                  armed_pre;
    logic [TIME_WIDTH-1:0] start_pre;
    logic [TIME_WIDTH-1:0] held_time;
    logic [TIME_WIDTH-1:0] idle_time;
    logic [TIME_WIDTH-1:0] long_ext;
    logic [TIME_WIDTH-1:0] lock_ext;

    always_comb begin
        case (poll.channel)
            CH_LEFT: begin
                press_ok = !poll.left_level && poll.mid_level && poll.right_level;
                released = poll.left_level;
            end
            CH_MIDDLE: begin
                press_ok = !poll.mid_level && poll.left_level && poll.right_level;
                released = poll.mid_level;
            end
            CH_RIGHT: begin
                press_ok = !poll.right_level && poll.left_level && poll.mid_level;
                released = poll.right_level;
            end
            default: begin
                press_ok = !poll.left_level && !poll.right_level && poll.mid_level;
                released = poll.left_level && poll.right_level;
            end
        endcase
    end

    assign long_ext = TIME_WIDTH'(cfg.long_press_ms);
    assign lock_ext = TIME_WIDTH'(cfg.lockout_ms);

    // arming happens first, the hold test sees the fresh start time
    assign armed_pre = cur.armed || (press_ok && !cur.lockout_active);
    assign start_pre = (press_ok && !cur.armed && !cur.lockout_active) ?
                       poll.time_ms : cur.press_start;
    assign held_time = poll.time_ms - start_pre;

    always_comb begin
        nxt = cur;
        nxt.armed = armed_pre;
        nxt.press_start = start_pre;
        kind = KIND_NONE;
        idle_time = poll.time_ms - cur.release_time;
        if (armed_pre && (held_time < long_ext) && released && !cur.lockout_active) begin
            nxt.armed = 1'b0;
            kind = KIND_SHORT;
        end else if (armed_pre && (held_time > long_ext) && !cur.lockout_active) begin
            nxt.held_block = 1'b1;
            nxt.lockout_active = 1'b1;
            nxt.armed = 1'b0;
            kind = KIND_LONG;
        end else begin
            if (cur.held_block && released) begin
                nxt.held_block = 1'b0;
                nxt.release_time = poll.time_ms;
                idle_time = '0;
            end
            if (!nxt.held_block && (idle_time > lock_ext)) begin
                nxt.lockout_active = 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/button_short_long_press_classifier.sv
// top level: poll register, per-channel state, result register and config registers
//
//  channel  | direction | payload                               | accepted when
//  s_       | in        | tuser channel, tdata levels and time  | s_tvalid & s_tready
//  m_       | out       | tdata press_kind, tuser channel_out   | m_tvalid & m_tready
//  cfg_     | in        | cfg_index, cfg_data                   | cfg_valid & cfg_ready
//
// one poll per cycle sustained while m_tready is high; a taken poll reaches m_
// through the poll register, then the result register
// reset clears all channel state and loads the default thresholds
// a stalled m_ side holds the result and lets one more poll wait in the poll register
module button_short_long_press_classifier (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] left_level, [1] mid_level, [2] right_level, [3 +: TIME_WIDTH] time_ms
    input  logic [bslp_pkg::S_TDATA_WIDTH-1:0]     s_tdata,
    // [1:0] channel
    input  logic [bslp_pkg::CH_WIDTH-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [1:0] press_kind
    output logic [bslp_pkg::M_TDATA_WIDTH-1:0]     m_tdata,
    // [1:0] channel_out
    output logic [bslp_pkg::CH_WIDTH-1:0]          m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bslp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [bslp_pkg::CFG_WIDTH-1:0]         cfg_data
);
    import bslp_pkg::*;

    logic                  in_valid_reg;
    poll_t                 poll_reg;
    logic                  out_valid_reg;
    logic [KIND_WIDTH-1:0] kind_reg;
    logic [CH_WIDTH-1:0]   chan_out_reg;
    cfg_t                  cfg_reg;
    chan_state_t           state_reg [NUM_CHANNELS];

    chan_state_t           cur_state;
    chan_state_t           state_next;
    logic [KIND_WIDTH-1:0] kind_next;
    logic                  advance;

    // result register frees up when empty or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign cur_state = state_reg[poll_reg.channel];

    bslp_chan_update u_chan_update (
        .poll (poll_reg),
        .cfg  (cfg_reg),
        .cur  (cur_state),
        .nxt  (state_next),
        .kind (kind_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            poll_reg.channel <= s_tuser;
            poll_reg.left_level <= s_tdata[0];
            poll_reg.mid_level <= s_tdata[1];
            poll_reg.right_level <= s_tdata[2];
            poll_reg.time_ms <= s_tdata[3 +: TIME_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg <= kind_next;
            chan_out_reg <= poll_reg.channel;
        end
    end

    // state commits in the same edge the transaction moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else if (advance) begin
            state_reg[poll_reg.channel] <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.lockout_ms <= LOCKOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_data;
                CFG_LOCKOUT:    cfg_reg.lockout_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = M_TDATA_WIDTH'(kind_reg);
    assign m_tuser = chan_out_reg;

endmodule
